FILE: sv/uss_pkg.sv
// ----------------------------------------------------------------------------
// uss_pkg
// shared constants and types for the unsorted set store
// ----------------------------------------------------------------------------
package uss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ELEM_W       = 32;
    localparam int OP_W         = 2;
    localparam int COUNT_OUT_W  = 7;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_ACT  = 5'b00100,
        ST_MOVE = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

endpackage

FILE: sv/unsorted_set_store.sv
// ----------------------------------------------------------------------------
// unsorted_set_store
// fixed-capacity set of distinct 32-bit elements held unordered in a ram
// ----------------------------------------------------------------------------
//  channel   direction  tdata                          tuser
//  s_        in         element[31:0]                  op[1:0]
//  m_        out        success, refused_full,         -
//                       count[6:0], is_empty
//
//  one item at a time: accept, a linear scan of the held entries through the
//  ram read port (one entry per cycle), an update step, an extra step for a
//  remove to move the last entry into the freed slot, and a result step. the
//  scan stops at the first hit; an empty set or a no-op skips it.
//  reset clears the state, the count, the scan flag and the output valid; the
//  ram needs no clearing.
//  a result waits in the output register while m_tready is low; the next
//  item is accepted meanwhile and holds at its result cycle.
// ----------------------------------------------------------------------------
module unsorted_set_store #(
    parameter int CAPACITY = uss_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uss_pkg::S_TDATA_W-1:0]  s_tdata,   // element[31:0]
    input  logic [uss_pkg::OP_W-1:0]       s_tuser,   // op[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [uss_pkg::M_TDATA_W-1:0]  m_tdata    // success, refused_full,
                                                      // count[6:0], is_empty, zeros
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = uss_pkg::ELEM_W;
    localparam int OW = uss_pkg::COUNT_OUT_W;

    uss_pkg::state_t state_reg, state_next;
    uss_pkg::op_t    op_reg, op_next;
    logic [EW-1:0]   elem_reg, elem_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic            pend_reg, pend_next;
    logic            found_reg, found_next;
    logic            ok_reg, ok_next;
    logic            refused_reg, refused_next;
    logic            m_valid_reg, m_valid_next;
    logic [uss_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;

    logic            hit;
    logic [CW-1:0]   idx_m1;
    logic [CW-1:0]   count_m1;
    logic [OW+CW-1:0] count_ext;
    logic            s_accept;
    logic            out_free;

    uss_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = state_reg == uss_pkg::ST_IDLE;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign hit       = pend_reg && (ram_rdata == elem_reg);
    assign idx_m1    = idx_reg - CW'(1);
    assign count_m1  = count_reg - CW'(1);
    assign count_ext = {{OW{1'b0}}, count_reg};
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        elem_next    = elem_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        pend_next    = 1'b0;
        found_next   = found_reg;
        ok_next      = ok_reg;
        refused_next = refused_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[AW-1:0];
        ram_wdata    = elem_reg;
        ram_raddr    = idx_reg[AW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            uss_pkg::ST_IDLE: begin
                if (s_accept) begin
                    op_next      = uss_pkg::op_t'(s_tuser);
                    elem_next    = s_tdata[EW-1:0];
                    idx_next     = '0;
                    found_next   = 1'b0;
                    ok_next      = 1'b0;
                    refused_next = 1'b0;
                    if (count_reg == '0 || s_tuser == uss_pkg::OP_NONE) begin
                        state_next = uss_pkg::ST_ACT;
                    end else begin
                        state_next = uss_pkg::ST_SCAN;
                    end
                end
            end
            uss_pkg::ST_SCAN: begin
                if (hit) begin
                    found_next = 1'b1;
                    slot_next  = idx_m1[AW-1:0];
                    state_next = uss_pkg::ST_ACT;
                end else if (idx_reg == count_reg) begin
                    state_next = uss_pkg::ST_ACT;
                end else begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
            end
            uss_pkg::ST_ACT: begin
                ram_raddr  = count_m1[AW-1:0];
                state_next = uss_pkg::ST_RESP;
                case (op_reg)
                    uss_pkg::OP_ADD: begin
                        if (!found_reg) begin
                            if (count_reg < CW'(CAPACITY)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end else begin
                                refused_next = 1'b1;
                            end
                        end
                    end
                    uss_pkg::OP_REMOVE: begin
                        if (found_reg) begin
                            state_next = uss_pkg::ST_MOVE;
                        end
                    end
                    uss_pkg::OP_SEARCH: begin
                        ok_next = found_reg;
                    end
                    default: begin
                    end
                endcase
            end
            uss_pkg::ST_MOVE: begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = ram_rdata;
                count_next = count_m1;
                ok_next    = 1'b1;
                state_next = uss_pkg::ST_RESP;
            end
            uss_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, (count_reg == '0), count_ext[OW-1:0],
                                    refused_reg, ok_reg};
                    state_next   = uss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = uss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= uss_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        elem_reg    <= elem_next;
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        ok_reg      <= ok_next;
        refused_reg <= refused_next;
        m_data_reg  <= m_data_next;
    end

endmodule

FILE: sv/uss_ram.sv
// ----------------------------------------------------------------------------
// uss_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module uss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sim/set_store_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_store_checker
// watches both stream channels of the set store, keeps a shadow copy of the
// held elements, predicts one result per accepted item and compares results
// in order, field by field
// ----------------------------------------------------------------------------
module set_store_checker
    import uss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // element[31:0]
    input  logic [OP_W-1:0]      s_tuser,   // op[1:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // success, refused_full, count[6:0], is_empty
    output int                   mismatch_count,
    output int                   results_pending,
    output int                   results_checked,
    output int                   full_refusals,
    output int                   peak_members
);

    typedef struct packed {
        logic                   success;
        logic                   refused_full;
        logic [COUNT_OUT_W-1:0] count;
        logic                   is_empty;
    } set_result_t;

    logic [ELEM_W-1:0] held_elements [CAPACITY];
    int                held_count;
    set_result_t       expected_results [$];

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
        results_checked = 0;
        full_refusals   = 0;
        peak_members    = 0;
        held_count      = 0;
    end

    function automatic set_result_t apply_request(op_t op, logic [ELEM_W-1:0] value);
        set_result_t r;
        int          slot;
        slot = -1;
        r    = '0;
        for (int i = 0; i < held_count && slot < 0; i++) begin
            if (held_elements[i] == value) begin
                slot = i;
            end
        end
        case (op)
            OP_ADD: begin
                if (slot < 0) begin
                    if (held_count >= CAPACITY) begin
                        r.refused_full = 1'b1;
                    end else begin
                        held_elements[held_count] = value;
                        held_count++;
                        r.success = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (slot >= 0) begin
                    held_elements[slot] = held_elements[held_count-1];
                    held_count--;
                    r.success = 1'b1;
                end
            end
            OP_SEARCH: begin
                r.success = (slot >= 0);
            end
            default: ;
        endcase
        r.count    = held_count[COUNT_OUT_W-1:0];
        r.is_empty = (held_count == 0);
        return r;
    endfunction

    always @(posedge aclk) begin
        set_result_t predicted;
        set_result_t observed;
        if (!aresetn) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                observed.success      = m_tdata[0];
                observed.refused_full = m_tdata[1];
                observed.count        = m_tdata[2 +: COUNT_OUT_W];
                observed.is_empty     = m_tdata[2+COUNT_OUT_W];
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result with nothing expected: success=%0b refused_full=%0b count=%0d is_empty=%0b",
                                 $realtime, observed.success, observed.refused_full,
                                 observed.count, observed.is_empty);
                    end
                    mismatch_count++;
                end else begin
                    predicted = expected_results.pop_front();
                    results_checked++;
                    if (predicted.refused_full) begin
                        full_refusals++;
                    end
                    if (observed !== predicted) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result %0d: expected success=%0b refused_full=%0b count=%0d is_empty=%0b, got success=%0b refused_full=%0b count=%0d is_empty=%0b",
                                     $realtime, results_checked,
                                     predicted.success, predicted.refused_full,
                                     predicted.count, predicted.is_empty,
                                     observed.success, observed.refused_full,
                                     observed.count, observed.is_empty);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_request(op_t'(s_tuser), s_tdata[ELEM_W-1:0]));
                if (held_count > peak_members) begin
                    peak_members = held_count;
                end
            end
        end
        results_pending = expected_results.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives add, remove, search and no-op items into the set store: a directed
// opening on the element extremes and special cases, then random bursts that
// fill, drain and mix a pool of recurring values, under three idle patterns
// and one long receiver hold-off; the checker module scores every result
// ----------------------------------------------------------------------------
module testbench;

    import uss_pkg::*;

    localparam int PHASE_ITEMS   = 545;
    localparam int POOL_SIZE     = 96;
    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = CAPACITY_DEF + 16;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BLEND
    } burst_mix_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = OP_NONE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int results_pending;
    int results_checked;
    int full_refusals;
    int peak_members;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  items_sent    = 0;
    int  hold_left     = 0;
    bit  hold_request  = 1'b0;
    int  idle_cycles   = 0;

    logic [ELEM_W-1:0] value_pool [POOL_SIZE];

    unsorted_set_store i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    set_store_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked),
        .full_refusals   (full_refusals),
        .peak_members    (peak_members)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // receiver side: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no item moving", IDLE_LIMIT);
            $display("unsorted_set_store: mismatch");
            $finish;
        end
    end

    task automatic send_request(input op_t op, input logic [ELEM_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        items_sent++;
    endtask

    function automatic op_t pick_op(burst_mix_t mix);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) begin
            return OP_NONE;
        end
        case (mix)
            MIX_FILL:  return (roll < 77) ? OP_ADD : (roll < 87) ? OP_REMOVE : OP_SEARCH;
            MIX_DRAIN: return (roll < 12) ? OP_ADD : (roll < 87) ? OP_REMOVE : OP_SEARCH;
            default:   return (roll < 37) ? OP_ADD : (roll < 67) ? OP_REMOVE : OP_SEARCH;
        endcase
    endfunction

    function automatic logic [ELEM_W-1:0] pick_element();
        if ($urandom_range(99) < 85) begin
            return value_pool[$urandom_range(POOL_SIZE-1)];
        end
        return $urandom;
    endfunction

    initial begin
        burst_mix_t mix;
        int         burst_left;
        for (int i = 0; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        burst_left = 0;
        mix        = MIX_FILL;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed opening
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_NONE,   32'h0000_0000);
        send_request(OP_ADD,    32'h8000_0000);
        send_request(OP_ADD,    32'h7FFF_FFFF);
        send_request(OP_ADD,    32'h0000_0000);
        send_request(OP_ADD,    32'hFFFF_FFFF);
        send_request(OP_ADD,    32'h7FFF_FFFF);
        send_request(OP_SEARCH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h0000_0005);
        send_request(OP_REMOVE, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h1234_5678);
        send_request(OP_NONE,   32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_ADD,    32'hA5A5_5A5A);
        send_request(OP_REMOVE, 32'hA5A5_5A5A);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 33 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    mix        = burst_mix_t'($urandom_range(2));
                    burst_left = $urandom_range(20, 120);
                end
                burst_left--;
                if ($urandom_range(99) < 3) begin
                    value_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
                end
                // long receiver hold-off while items keep coming
                if (phase == 2 && n == 100) begin
                    hold_request = 1'b1;
                end
                send_request(pick_op(mix), pick_element());
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items (adds, removes, searches, no-ops), %0d results checked",
                 items_sent, results_checked);
        $display("%0d adds refused on a full set, peak of %0d elements held",
                 full_refusals, peak_members);
        if (mismatch_count == 0) begin
            $display("unsorted_set_store: match");
        end else begin
            $display("unsorted_set_store: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/uss_pkg.sv
sv/uss_ram.sv
sv/unsorted_set_store.sv
sim/set_store_checker.sv
sim/testbench.sv
